### rtl/core/pps_pkg.sv
// Shared types, constants and tables for the pure pursuit steering core.
`timescale 1ns / 1ps
`default_nettype none

package pps_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_LOOKAHEAD = 2'd0;
  localparam logic [1:0] REG_WHEELBASE = 2'd1;
  localparam logic [1:0] REG_TRACK     = 2'd2;

  // Register reset values
  localparam logic [30:0] LOOKAHEAD_RESET = 31'd131072;
  localparam logic [30:0] WHEELBASE_RESET = 31'd18350;
  localparam logic [30:0] TRACK_RESET     = 31'd16384;

  // Result status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_ZERO_LEG = 2'd1;
  localparam logic [1:0] STATUS_SAT      = 2'd2;

  // Heading folding, hundredths of a degree
  localparam logic [16:0] HEAD_FULL    = 17'd36000;
  localparam logic [16:0] HEAD_HALF    = 17'd18000;
  localparam logic [16:0] HEAD_QUARTER = 17'd9000;
  localparam logic [16:0] HEAD_3QUART  = 17'd27000;

  // Iterative unit step counts
  localparam int unsigned CORDIC_STEPS = 20;
  localparam int unsigned SQRT_STEPS   = 32;
  localparam int unsigned DIV_STEPS    = 64;

  localparam logic signed [33:0] CORDIC_GAIN_Q24 = 34'sd10188014;
  localparam logic [14:0]        STEER_MAX       = 15'd9000;

  // Register file contents handed to the datapath
  typedef struct packed {
    logic [30:0] lookahead;
    logic [30:0] wheelbase;
    logic [30:0] track;
  } cfg_t;

  // One input transaction
  typedef struct packed {
    logic [15:0]        heading;
    logic signed [31:0] robot_x;
    logic signed [31:0] robot_y;
    logic signed [31:0] from_x;
    logic signed [31:0] from_y;
    logic signed [31:0] to_x;
    logic signed [31:0] to_y;
  } in_item_t;

  // One result transaction
  typedef struct packed {
    logic signed [14:0] steer_angle;
    logic [1:0]         status;
  } out_item_t;

  // Classified job passed from front to back
  typedef struct packed {
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [32:0] rx;
    logic signed [32:0] ry;
    logic signed [23:0] z0;
    logic               flip;
    logic               zero_leg;
  } job_t;

  // CORDIC arctangent table, units of 1/25600 degree
  function automatic logic [20:0] cordic_atan(input logic [4:0] idx);
    logic [20:0] v;
    case (idx)
      5'd0:  v = 21'd1152000;
      5'd1:  v = 21'd680065;
      5'd2:  v = 21'd359328;
      5'd3:  v = 21'd182400;
      5'd4:  v = 21'd91554;
      5'd5:  v = 21'd45822;
      5'd6:  v = 21'd22916;
      5'd7:  v = 21'd11459;
      5'd8:  v = 21'd5730;
      5'd9:  v = 21'd2865;
      5'd10: v = 21'd1432;
      5'd11: v = 21'd716;
      5'd12: v = 21'd358;
      5'd13: v = 21'd179;
      5'd14: v = 21'd90;
      5'd15: v = 21'd45;
      5'd16: v = 21'd22;
      5'd17: v = 21'd11;
      5'd18: v = 21'd6;
      5'd19: v = 21'd3;
      default: v = 21'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

### rtl/core/pps_fifo.sv
// Small synchronous queue with push/full and pop/empty sides.
`timescale 1ns / 1ps
`default_nettype none

module pps_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      data_o,
  output logic                  empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]    count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/pps_front.sv
// Front end: takes input transactions, forms leg vectors and folds the heading.
`timescale 1ns / 1ps
`default_nettype none

module pps_front (
  input  wire pps_pkg::in_item_t item_i,
  output pps_pkg::job_t          job_o
);

  logic [16:0]        h_ext, h_mod;
  logic signed [17:0] h_fold;
  logic               flip;

  // Leg and robot offset vectors, zero-length leg check
  always_comb begin
    job_o.dx = 33'(item_i.to_x) - 33'(item_i.from_x);
    job_o.dy = 33'(item_i.to_y) - 33'(item_i.from_y);
    job_o.rx = 33'(item_i.robot_x) - 33'(item_i.from_x);
    job_o.ry = 33'(item_i.robot_y) - 33'(item_i.from_y);
    job_o.zero_leg = (job_o.dx == '0) && (job_o.dy == '0);
  end

  // Heading modulo a full turn, then folded into [-90, 90] degrees
  always_comb begin
    h_ext = {1'b0, item_i.heading};
    h_mod = (h_ext >= pps_pkg::HEAD_FULL) ? h_ext - pps_pkg::HEAD_FULL : h_ext;
    flip  = 1'b0;
    if (h_mod > pps_pkg::HEAD_3QUART) begin
      h_fold = $signed({1'b0, h_mod}) - $signed({1'b0, pps_pkg::HEAD_FULL});
    end else if (h_mod > pps_pkg::HEAD_QUARTER) begin
      h_fold = $signed({1'b0, h_mod}) - $signed({1'b0, pps_pkg::HEAD_HALF});
      flip   = 1'b1;
    end else begin
      h_fold = $signed({1'b0, h_mod});
    end
    job_o.z0   = {h_fold[15:0], 8'd0};
    job_o.flip = flip;
  end

endmodule

`default_nettype wire

### rtl/core/pps_back.sv
// Back end: sequencer with shared multiplier, divider, square root and CORDIC.
`timescale 1ns / 1ps
`default_nettype none

module pps_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire pps_pkg::cfg_t     cfg_i,
  input  wire pps_pkg::job_t     job_i,
  input  wire logic              job_empty_i,
  output logic                   job_pop_o,
  output pps_pkg::out_item_t     res_o,
  output logic                   res_push_o,
  input  wire logic              res_full_i
);

  typedef enum logic [5:0] {
    S_IDLE, S_NORM, S_LEN1, S_LEN2, S_LEN3, S_SQRT, S_DIV, S_CORD,
    S_UX, S_UY, S_CS0, S_CS1, S_CS2, S_CS3, S_CS4, S_LA,
    S_NG1, S_NG2, S_NG3, S_HD,
    S_CU0, S_CU1, S_CU2, S_CU3, S_CU4, S_CU5, S_CU6, S_CU7,
    S_B0, S_B1, S_B2, S_B3, S_B4, S_Q,
    S_TQ0, S_TQ1, S_TQ2, S_TQ3, S_NUM,
    S_AS0, S_AS1, S_AS2, S_AS3, S_AS4, S_EMIT
  } state_e;

  // Round half away from zero while dropping 24 fraction bits
  function automatic logic signed [44:0] rnd24(input logic signed [67:0] v);
    logic [67:0] m;
    logic [67:0] r;
    m = v[67] ? 68'(-v) : 68'(v);
    r = (m + 68'h80_0000) >> 24;
    return v[67] ? -$signed(r[44:0]) : $signed(r[44:0]);
  endfunction

  state_e state_q, ret_q;
  logic [5:0] cnt_q;

  // Datapath registers
  logic [32:0]        mx_q, my_q;
  logic               dxneg_q, dyneg_q, flip_q;
  logic signed [32:0] rx_q, ry_q;
  logic signed [23:0] z0_q;
  logic [31:0]        len_q;
  logic signed [25:0] ux_q, uy_q;
  logic signed [31:0] cs_q;
  logic [30:0]        cte_q;
  logic [31:0]        la_q, ngd_q, den_q;
  logic signed [33:0] c_q, s_q;
  logic signed [32:0] cu_q, cv_q;
  logic signed [35:0] b_q;
  logic [30:0]        q_q, tq_q;
  logic [62:0]        num_q;
  logic [29:0]        a_q;
  logic signed [32:0] ma_q, mb_q;
  logic signed [65:0] p_q;
  logic signed [67:0] acc_q;
  logic [63:0]        sq_v_q, sq_r_q, sq_b_q;
  logic [63:0]        dv_n_q;
  logic [31:0]        dv_r_q, dv_d_q;
  logic signed [33:0] cx_q, cy_q;
  logic signed [24:0] cz_q;
  logic               cmode_q;
  pps_pkg::out_item_t res_q;

  // Multiplier: product registered every cycle
  always_ff @(posedge clk_i) begin
    p_q <= ma_q * mb_q;
  end

  // Normalization magnitude
  logic [32:0] m_max;
  assign m_max = (mx_q > my_q) ? mx_q : my_q;

  // Restoring divider step
  logic [32:0] dv_sh, dv_sub;
  logic        dv_ge;
  assign dv_sh  = {dv_r_q, dv_n_q[63]};
  assign dv_ge  = (dv_sh >= {1'b0, dv_d_q});
  assign dv_sub = dv_sh - {1'b0, dv_d_q};

  // Bitwise square root step
  logic [64:0] sq_t;
  logic        sq_ge;
  assign sq_t  = {1'b0, sq_r_q} + {1'b0, sq_b_q};
  assign sq_ge = ({1'b0, sq_v_q} >= sq_t);

  // CORDIC step, rotation and vectoring share one datapath
  logic signed [33:0] cd_tx, cd_ty;
  logic signed [24:0] cd_at;
  logic               cd_pos;
  assign cd_tx  = cx_q >>> cnt_q[4:0];
  assign cd_ty  = cy_q >>> cnt_q[4:0];
  assign cd_at  = $signed({4'd0, pps_pkg::cordic_atan(cnt_q[4:0])});
  assign cd_pos = cmode_q ? (cy_q <= 34'sd0) : (cz_q >= 25'sd0);

  // Helpers for individual steps
  logic signed [25:0]  ux_w, uy_w;
  logic signed [44:0]  rnd_w;
  logic signed [31:0]  cs_neg;
  logic [30:0]         cte_w;
  logic [31:0]         la_w;
  logic signed [33:0]  c_w, s_w;
  logic signed [35:0]  b_neg;
  logic [35:0]         bm_w;
  logic [67:0]         acc_sum, acc_dif;
  logic [61:0]         den_sh;
  logic [23:0]         z_pos;
  logic [24:0]         z_rnd;
  logic [14:0]         mag_w;
  logic signed [14:0]  sat_w;

  always_comb begin
    ux_w    = dxneg_q ? -$signed({1'b0, dv_n_q[24:0]}) : $signed({1'b0, dv_n_q[24:0]});
    uy_w    = dyneg_q ? -$signed({1'b0, dv_n_q[24:0]}) : $signed({1'b0, dv_n_q[24:0]});
    rnd_w   = rnd24(acc_q);
    cs_neg  = -cs_q;
    cte_w   = cs_q[31] ? cs_neg[30:0] : cs_q[30:0];
    la_w    = (cte_w <= cfg_i.lookahead) ? {1'b0, cfg_i.lookahead}
                                         : {1'b0, cfg_i.lookahead} + {1'b0, cte_w};
    c_w     = flip_q ? -cx_q : cx_q;
    s_w     = flip_q ? -cy_q : cy_q;
    b_neg   = -b_q;
    bm_w    = b_q[35] ? b_neg : b_q;
    acc_sum = acc_q + 68'(p_q);
    acc_dif = acc_q - 68'(p_q);
    den_sh  = {den_q, 30'd0};
    z_pos   = cz_q[24] ? 24'd0 : cz_q[23:0];
    z_rnd   = ({1'b0, z_pos} + 25'd128) >> 8;
    mag_w   = (z_rnd > 25'(pps_pkg::STEER_MAX)) ? pps_pkg::STEER_MAX : z_rnd[14:0];
    sat_w   = b_q[35] ? -$signed(pps_pkg::STEER_MAX) : $signed(pps_pkg::STEER_MAX);
  end

  assign job_pop_o  = (state_q == S_IDLE) && !job_empty_i;
  assign res_push_o = (state_q == S_EMIT);
  assign res_o      = res_q;

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
      cnt_q   <= '0;
      mx_q <= '0; my_q <= '0; dxneg_q <= 1'b0; dyneg_q <= 1'b0; flip_q <= 1'b0;
      rx_q <= '0; ry_q <= '0; z0_q <= '0; len_q <= '0; ux_q <= '0; uy_q <= '0;
      cs_q <= '0; cte_q <= '0; la_q <= '0; ngd_q <= '0; den_q <= '0;
      c_q <= '0; s_q <= '0; cu_q <= '0; cv_q <= '0; b_q <= '0;
      q_q <= '0; tq_q <= '0; num_q <= '0; a_q <= '0;
      ma_q <= '0; mb_q <= '0; acc_q <= '0;
      sq_v_q <= '0; sq_r_q <= '0; sq_b_q <= '0;
      dv_n_q <= '0; dv_r_q <= '0; dv_d_q <= '0;
      cx_q <= '0; cy_q <= '0; cz_q <= '0; cmode_q <= 1'b0;
      res_q <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (!job_empty_i) begin
            rx_q    <= job_i.rx;
            ry_q    <= job_i.ry;
            z0_q    <= job_i.z0;
            flip_q  <= job_i.flip;
            dxneg_q <= job_i.dx[32];
            dyneg_q <= job_i.dy[32];
            mx_q    <= job_i.dx[32] ? 33'(-job_i.dx) : 33'(job_i.dx);
            my_q    <= job_i.dy[32] ? 33'(-job_i.dy) : 33'(job_i.dy);
            if (job_i.zero_leg) begin
              res_q.steer_angle <= '0;
              res_q.status      <= pps_pkg::STATUS_ZERO_LEG;
              state_q           <= S_EMIT;
            end else begin
              state_q <= S_NORM;
            end
          end
        end
        // Scale the leg so its larger component lies in [2^30, 2^31)
        S_NORM: begin
          if (m_max[32] || m_max[31]) begin
            mx_q <= mx_q >> 1;
            my_q <= my_q >> 1;
          end else if (!m_max[30]) begin
            mx_q <= mx_q << 1;
            my_q <= my_q << 1;
          end else begin
            ma_q    <= $signed(mx_q);
            mb_q    <= $signed(mx_q);
            state_q <= S_LEN1;
          end
        end
        S_LEN1: begin
          ma_q    <= $signed(my_q);
          mb_q    <= $signed(my_q);
          state_q <= S_LEN2;
        end
        S_LEN2: begin
          acc_q   <= 68'(p_q);
          state_q <= S_LEN3;
        end
        S_LEN3: begin
          sq_v_q  <= acc_sum[63:0];
          sq_r_q  <= '0;
          sq_b_q  <= 64'h4000_0000_0000_0000;
          cnt_q   <= '0;
          ret_q   <= S_UX;
          state_q <= S_SQRT;
        end
        S_SQRT: begin
          if (sq_ge) begin
            sq_v_q <= sq_v_q - sq_t[63:0];
            sq_r_q <= (sq_r_q >> 1) + sq_b_q;
          end else begin
            sq_r_q <= sq_r_q >> 1;
          end
          sq_b_q <= sq_b_q >> 2;
          cnt_q  <= cnt_q + 1'b1;
          if (cnt_q == 6'(pps_pkg::SQRT_STEPS - 1)) begin
            state_q <= ret_q;
          end
        end
        S_DIV: begin
          dv_r_q <= dv_ge ? dv_sub[31:0] : dv_sh[31:0];
          dv_n_q <= {dv_n_q[62:0], dv_ge};
          cnt_q  <= cnt_q + 1'b1;
          if (cnt_q == 6'(pps_pkg::DIV_STEPS - 1)) begin
            state_q <= ret_q;
          end
        end
        S_CORD: begin
          if (cd_pos) begin
            cx_q <= cx_q - cd_ty;
            cy_q <= cy_q + cd_tx;
            cz_q <= cz_q - cd_at;
          end else begin
            cx_q <= cx_q + cd_ty;
            cy_q <= cy_q - cd_tx;
            cz_q <= cz_q + cd_at;
          end
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 6'(pps_pkg::CORDIC_STEPS - 1)) begin
            state_q <= ret_q;
          end
        end
        // Leg unit vector, Q24
        S_UX: begin
          len_q   <= sq_r_q[31:0];
          dv_n_q  <= (64'(mx_q) << 24) + 64'(sq_r_q[31:1]);
          dv_r_q  <= '0;
          dv_d_q  <= sq_r_q[31:0];
          cnt_q   <= '0;
          ret_q   <= S_UY;
          state_q <= S_DIV;
        end
        S_UY: begin
          ux_q    <= ux_w;
          dv_n_q  <= (64'(my_q) << 24) + 64'(len_q[31:1]);
          dv_r_q  <= '0;
          dv_d_q  <= len_q;
          cnt_q   <= '0;
          ret_q   <= S_CS0;
          state_q <= S_DIV;
        end
        // Signed cross-track error
        S_CS0: begin
          uy_q    <= uy_w;
          ma_q    <= rx_q;
          mb_q    <= 33'(uy_w);
          state_q <= S_CS1;
        end
        S_CS1: begin
          ma_q    <= ry_q;
          mb_q    <= 33'(ux_q);
          state_q <= S_CS2;
        end
        S_CS2: begin
          acc_q   <= 68'(p_q);
          state_q <= S_CS3;
        end
        S_CS3: begin
          acc_q   <= acc_dif;
          state_q <= S_CS4;
        end
        S_CS4: begin
          if (rnd_w > 45'sd2147483647) begin
            cs_q <= 32'sh7FFF_FFFF;
          end else if (rnd_w < -45'sd2147483647) begin
            cs_q <= -32'sh7FFF_FFFF;
          end else begin
            cs_q <= rnd_w[31:0];
          end
          state_q <= S_LA;
        end
        // Lookahead and goal distance along the leg
        S_LA: begin
          cte_q   <= cte_w;
          la_q    <= la_w;
          ma_q    <= $signed({1'b0, la_w});
          mb_q    <= $signed({1'b0, la_w});
          state_q <= S_NG1;
        end
        S_NG1: begin
          ma_q    <= $signed({2'b0, cte_q});
          mb_q    <= $signed({2'b0, cte_q});
          state_q <= S_NG2;
        end
        S_NG2: begin
          acc_q   <= 68'(p_q);
          state_q <= S_NG3;
        end
        S_NG3: begin
          sq_v_q  <= acc_dif[63:0];
          sq_r_q  <= '0;
          sq_b_q  <= 64'h4000_0000_0000_0000;
          cnt_q   <= '0;
          ret_q   <= S_HD;
          state_q <= S_SQRT;
        end
        // Heading cosine and sine
        S_HD: begin
          ngd_q   <= sq_r_q[31:0];
          cx_q    <= pps_pkg::CORDIC_GAIN_Q24;
          cy_q    <= '0;
          cz_q    <= 25'(z0_q);
          cmode_q <= 1'b0;
          cnt_q   <= '0;
          ret_q   <= S_CU0;
          state_q <= S_CORD;
        end
        // Heading projected along and across the leg
        S_CU0: begin
          c_q     <= c_w;
          s_q     <= s_w;
          ma_q    <= 33'(ux_q);
          mb_q    <= c_w[32:0];
          state_q <= S_CU1;
        end
        S_CU1: begin
          ma_q    <= 33'(uy_q);
          mb_q    <= s_q[32:0];
          state_q <= S_CU2;
        end
        S_CU2: begin
          acc_q   <= 68'(p_q);
          state_q <= S_CU3;
        end
        S_CU3: begin
          acc_q   <= acc_dif;
          ma_q    <= 33'(uy_q);
          mb_q    <= c_q[32:0];
          state_q <= S_CU4;
        end
        S_CU4: begin
          cu_q    <= rnd_w[32:0];
          ma_q    <= 33'(ux_q);
          mb_q    <= s_q[32:0];
          state_q <= S_CU5;
        end
        S_CU5: begin
          acc_q   <= 68'(p_q);
          state_q <= S_CU6;
        end
        S_CU6: begin
          acc_q   <= acc_sum;
          state_q <= S_CU7;
        end
        S_CU7: begin
          cv_q    <= rnd_w[32:0];
          ma_q    <= $signed({1'b0, ngd_q});
          mb_q    <= cu_q;
          state_q <= S_B0;
        end
        // Lateral goal offset in the robot frame
        S_B0: begin
          ma_q    <= 33'(cs_q);
          mb_q    <= cv_q;
          state_q <= S_B1;
        end
        S_B1: begin
          acc_q   <= 68'(p_q);
          state_q <= S_B2;
        end
        S_B2: begin
          acc_q   <= acc_dif;
          state_q <= S_B3;
        end
        S_B3: begin
          b_q     <= rnd_w[35:0];
          state_q <= S_B4;
        end
        S_B4: begin
          if (b_q == '0 || la_q == '0) begin
            res_q.steer_angle <= '0;
            res_q.status      <= pps_pkg::STATUS_OK;
            state_q           <= S_EMIT;
          end else if (bm_w >= 36'(la_q)) begin
            q_q     <= 31'h4000_0000;
            state_q <= S_TQ0;
          end else begin
            dv_n_q  <= {bm_w[33:0], 30'd0};
            dv_r_q  <= '0;
            dv_d_q  <= la_q;
            cnt_q   <= '0;
            ret_q   <= S_Q;
            state_q <= S_DIV;
          end
        end
        S_Q: begin
          q_q     <= dv_n_q[30:0];
          state_q <= S_TQ0;
        end
        // Half-track correction and asin argument
        S_TQ0: begin
          ma_q    <= $signed({2'b0, cfg_i.track});
          mb_q    <= $signed({2'b0, q_q});
          state_q <= S_TQ1;
        end
        S_TQ1: begin
          ma_q    <= $signed({2'b0, cfg_i.wheelbase});
          mb_q    <= $signed({2'b0, q_q});
          state_q <= S_TQ2;
        end
        S_TQ2: begin
          tq_q    <= p_q[60:30];
          state_q <= S_TQ3;
        end
        S_TQ3: begin
          num_q <= {p_q[61:0], 1'b0};
          den_q <= la_q - 32'(tq_q);
          if (32'(tq_q) >= la_q) begin
            res_q.steer_angle <= sat_w;
            res_q.status      <= pps_pkg::STATUS_SAT;
            state_q           <= S_EMIT;
          end else begin
            state_q <= S_NUM;
          end
        end
        S_NUM: begin
          if (num_q > 63'(den_sh)) begin
            res_q.steer_angle <= sat_w;
            res_q.status      <= pps_pkg::STATUS_SAT;
            state_q           <= S_EMIT;
          end else if (num_q == 63'(den_sh)) begin
            res_q.steer_angle <= sat_w;
            res_q.status      <= pps_pkg::STATUS_OK;
            state_q           <= S_EMIT;
          end else begin
            dv_n_q  <= 64'(num_q);
            dv_r_q  <= '0;
            dv_d_q  <= den_q;
            cnt_q   <= '0;
            ret_q   <= S_AS0;
            state_q <= S_DIV;
          end
        end
        // asin through atan of a over sqrt(1 - a^2)
        S_AS0: begin
          a_q     <= dv_n_q[29:0];
          ma_q    <= $signed({3'b0, dv_n_q[29:0]});
          mb_q    <= $signed({3'b0, dv_n_q[29:0]});
          state_q <= S_AS1;
        end
        S_AS1: begin
          state_q <= S_AS2;
        end
        S_AS2: begin
          sq_v_q  <= 64'h1000_0000_0000_0000 - 64'(p_q[59:0]);
          sq_r_q  <= '0;
          sq_b_q  <= 64'h4000_0000_0000_0000;
          cnt_q   <= '0;
          ret_q   <= S_AS3;
          state_q <= S_SQRT;
        end
        S_AS3: begin
          cx_q    <= $signed({3'b0, sq_r_q[30:0]});
          cy_q    <= $signed({4'b0, a_q});
          cz_q    <= '0;
          cmode_q <= 1'b1;
          cnt_q   <= '0;
          ret_q   <= S_AS4;
          state_q <= S_CORD;
        end
        S_AS4: begin
          res_q.steer_angle <= b_q[35] ? -$signed(mag_w) : $signed(mag_w);
          res_q.status      <= pps_pkg::STATUS_OK;
          state_q           <= S_EMIT;
        end
        S_EMIT: begin
          if (!res_full_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/core/pure_pursuit_steering_core.sv
// Top level of the pure pursuit Ackermann steering core.
//
//  Channel   Ports                               Direction  Accepted when
//  input     push, full, in_item_i               in         push && !full
//  result    pop, empty, out_item_o              out        pop && !empty
//  config    cfg_we_i, cfg_idx_i, cfg_wdata_i    in         cfg_we_i
//
// A zero-length leg goes straight to its result; for any other item the
// bit-serial divider sets most of the run time (two to four quotients per
// item), then the bitwise square root (two or three roots), the 20-step
// CORDIC and up to 30 normalization shifts.
// Reset clears the queues and loads the register reset values; no clearing
// pass. The input queue accepts until full; the back end holds a finished
// result until the result queue has room.
`timescale 1ns / 1ps
`default_nettype none

module pure_pursuit_steering_core #(
  parameter int unsigned JOB_DEPTH = 2,
  parameter int unsigned RES_DEPTH = 2
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push,
  output logic                   full,
  input  wire pps_pkg::in_item_t in_item_i,
  input  wire logic              pop,
  output logic                   empty,
  output pps_pkg::out_item_t     out_item_o,
  input  wire logic              cfg_we_i,
  input  wire logic [1:0]        cfg_idx_i,
  input  wire logic [30:0]       cfg_wdata_i
);

  pps_pkg::cfg_t      cfg_q;
  pps_pkg::job_t      job_in, job_out;
  pps_pkg::out_item_t res;
  logic               job_empty, job_pop, res_push, res_full;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lookahead <= pps_pkg::LOOKAHEAD_RESET;
      cfg_q.wheelbase <= pps_pkg::WHEELBASE_RESET;
      cfg_q.track     <= pps_pkg::TRACK_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pps_pkg::REG_LOOKAHEAD: cfg_q.lookahead <= cfg_wdata_i;
        pps_pkg::REG_WHEELBASE: cfg_q.wheelbase <= cfg_wdata_i;
        pps_pkg::REG_TRACK:     cfg_q.track     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Front end: classify incoming transactions
  pps_front u_front (
    .item_i (in_item_i),
    .job_o  (job_in)
  );

  // Job queue between front and back
  pps_fifo #(
    .WIDTH ($bits(pps_pkg::job_t)),
    .DEPTH (JOB_DEPTH)
  ) u_job_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .full_o  (full),
    .pop_i   (job_pop),
    .data_o  (job_out),
    .empty_o (job_empty)
  );

  // Back end: steering arithmetic
  pps_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_i       (job_out),
    .job_empty_i (job_empty),
    .job_pop_o   (job_pop),
    .res_o       (res),
    .res_push_o  (res_push),
    .res_full_i  (res_full)
  );

  // Result queue
  pps_fifo #(
    .WIDTH ($bits(pps_pkg::out_item_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (out_item_o),
    .empty_o (empty)
  );

endmodule

`default_nettype wire
